[hw/rtl/hadamard_block_edge_detector_core_macros.svh]
// ----------------------------------------------------------------------------
// hadamard_block_edge_detector_core_macros.svh
// assertion macros for the block edge detector, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef HADAMARD_BLOCK_EDGE_DETECTOR_CORE_MACROS_SVH
`define HADAMARD_BLOCK_EDGE_DETECTOR_CORE_MACROS_SVH

`ifndef SYNTHESIS

// expression holds at every clock edge out of reset
`define HBED_ASSERT_HOLDS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define HBED_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define HBED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define HBED_ASSERT_HOLDS(label, clk, rst_n, expr, msg)
`define HBED_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define HBED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

[hw/rtl/hbed_pkg.sv]
// ----------------------------------------------------------------------------
// hbed_pkg
// shared types and constants of the hadamard block edge detector
// ----------------------------------------------------------------------------
`default_nettype none

package hbed_pkg;

    // configuration register indexes
    localparam int HBED_IDX_W = 2;
    localparam logic [HBED_IDX_W-1:0] CFG_IDX_IMAGE_WIDTH = 2'd0;
    localparam logic [HBED_IDX_W-1:0] CFG_IDX_THRESHOLD   = 2'd1;

    // configuration field widths and reset values
    localparam int HBED_CFG_DATA_W = 14;
    localparam int HBED_IMG_W_W    = 11;
    localparam int HBED_THR_W      = 14;
    localparam logic [HBED_IMG_W_W-1:0] HBED_IMG_W_RESET = 11'd1024;
    localparam logic [HBED_THR_W-1:0]   HBED_THR_RESET   = 14'd0;

    // pixel and block index widths
    localparam int HBED_PIX_W = 8;
    localparam int HBED_BLK_W = 9;

    // queue between front and back
    localparam int HBED_QDEPTH = 4;
    localparam int HBED_QAW    = 2;
    localparam int HBED_QCW    = 3;

    // one 2x2 block ready for the variance test
    typedef struct packed {
        logic [HBED_PIX_W-1:0] a;
        logic [HBED_PIX_W-1:0] b;
        logic [HBED_PIX_W-1:0] c;
        logic [HBED_PIX_W-1:0] d;
        logic [HBED_BLK_W-1:0] block_col;
        logic [HBED_BLK_W-1:0] block_row;
    } hbed_job_t;

endpackage

`default_nettype wire

[hw/rtl/hbed_ram.sv]
// ----------------------------------------------------------------------------
// hbed_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module hbed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/hbed_front.sv]
// ----------------------------------------------------------------------------
// hbed_front
// raster position tracking, line store access and block assembly
// ----------------------------------------------------------------------------
`default_nettype none

module hbed_front
    import hbed_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    output logic                         full,
    input  wire logic [HBED_PIX_W-1:0]   pixel,
    input  wire logic                    frame_start,
    input  wire logic [HBED_IMG_W_W-1:0] image_width,
    input  wire logic [HBED_QCW-1:0]     q_count,
    output logic                         job_valid,
    output hbed_job_t                    job
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = ($clog2(MAX_WIDTH + 1) > HBED_IMG_W_W) ?
                         $clog2(MAX_WIDTH + 1) : HBED_IMG_W_W;
    localparam int CXW = (CW > HBED_BLK_W + 1) ? CW : HBED_BLK_W + 1;
    localparam int RXW = (RW > HBED_BLK_W + 1) ? RW : HBED_BLK_W + 1;

    // next row index with wrap at the frame height
    function automatic logic [RW-1:0] row_inc(input logic [RW-1:0] r);
        logic [RW:0] t;
        t = {1'b0, r} + (RW+1)'(1);
        if (t >= (RW+1)'(MAX_HEIGHT))
        begin
            return '0;
        end
        return t[RW-1:0];
    endfunction

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [WW-1:0] w_ext, w_eff;
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;
    logic [WW-1:0] col_inc;
    logic          accept;

    logic                  s1_valid_reg;
    logic                  s1_odd_row_reg;
    logic                  s1_odd_col_reg;
    logic [HBED_PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]         s1_col_reg;
    logic [RW-1:0]         s1_row_reg;
    logic [HBED_PIX_W-1:0] left_reg;
    logic [HBED_PIX_W-1:0] upper_left_reg;
    logic [HBED_PIX_W-1:0] rdata;
    logic [CXW-1:0]        s1_col_x;
    logic [RXW-1:0]        s1_row_x;
    logic [HBED_QCW:0]     q_load;

    // room for this transaction and the one still in the store read stage
    assign q_load = {1'b0, q_count} + (HBED_QCW+1)'(job_valid);
    assign full   = q_load >= (HBED_QCW+1)'(HBED_QDEPTH);
    assign accept = push && !full;

    // effective width clamped to two and the store depth
    always_comb
    begin
        w_ext = WW'(image_width);
        if (w_ext < WW'(2))
        begin
            w_eff = WW'(2);
        end
        else if (w_ext > WW'(MAX_WIDTH))
        begin
            w_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = w_ext;
        end
    end

    // position of this pixel and of the one after it
    always_comb
    begin
        cur_col = col_reg;
        cur_row = row_reg;
        if (frame_start)
        begin
            cur_col = '0;
            cur_row = '0;
        end
        else if (WW'(col_reg) >= w_eff)
        begin
            cur_col = '0;
            cur_row = row_inc(row_reg);
        end
        col_inc = WW'(cur_col) + WW'(1);
        if (col_inc >= w_eff)
        begin
            col_next = '0;
            row_next = row_inc(cur_row);
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // upper rows are written, lower rows read back the pixel above
    hbed_ram #(
        .WIDTH (HBED_PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (accept && !cur_row[0]),
        .waddr (cur_col),
        .wdata (pixel),
        .re    (accept && cur_row[0]),
        .raddr (cur_col),
        .rdata (rdata)
    );

    // store read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_odd_row_reg <= cur_row[0];
            s1_odd_col_reg <= cur_col[0];
            s1_pixel_reg   <= pixel;
            s1_col_reg     <= cur_col;
            s1_row_reg     <= cur_row;
        end
    end

    // previous pixel of the stream
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
        end
        else if (s1_valid_reg)
        begin
            left_reg <= s1_pixel_reg;
        end
    end

    // upper left pixel comes back with the even column of a lower row
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_odd_row_reg && !s1_odd_col_reg)
        begin
            upper_left_reg <= rdata;
        end
    end

    // a complete block on the lower right pixel
    assign s1_col_x      = CXW'(s1_col_reg);
    assign s1_row_x      = RXW'(s1_row_reg);
    assign job_valid     = s1_valid_reg && s1_odd_row_reg && s1_odd_col_reg;
    assign job.a         = upper_left_reg;
    assign job.b         = rdata;
    assign job.c         = left_reg;
    assign job.d         = s1_pixel_reg;
    assign job.block_col = s1_col_x[HBED_BLK_W:1];
    assign job.block_row = s1_row_x[HBED_BLK_W:1];

endmodule

`default_nettype wire

[hw/rtl/hbed_queue.sv]
// ----------------------------------------------------------------------------
// hbed_queue
// short block queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module hbed_queue
    import hbed_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                wr_en,
    input  wire hbed_job_t           wr_data,
    input  wire logic                rd_en,
    output hbed_job_t                rd_data,
    output logic [HBED_QCW-1:0]      count,
    output logic                     empty
);

    hbed_job_t             entry_reg [HBED_QDEPTH];
    logic [HBED_QAW-1:0]   wptr_reg, wptr_next;
    logic [HBED_QAW-1:0]   rptr_reg, rptr_next;
    logic [HBED_QCW-1:0]   count_reg, count_next;

    // pointer and fill count update
    always_comb
    begin
        wptr_next  = wr_en ? wptr_reg + HBED_QAW'(1) : wptr_reg;
        rptr_next  = rd_en ? rptr_reg + HBED_QAW'(1) : rptr_reg;
        count_next = count_reg + HBED_QCW'(wr_en) - HBED_QCW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

    assign rd_data = entry_reg[rptr_reg];
    assign count   = count_reg;
    assign empty   = (count_reg == '0);

endmodule

`default_nettype wire

[hw/rtl/hbed_back.sv]
// ----------------------------------------------------------------------------
// hbed_back
// hadamard ac coefficients and variance test, one block per cycle unless pop stalls the output
// ----------------------------------------------------------------------------
`default_nettype none

module hbed_back
    import hbed_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  q_empty,
    input  wire hbed_job_t             q_head,
    output logic                       q_rd,
    input  wire logic [HBED_THR_W-1:0] variance_threshold,
    input  wire logic                  pop,
    output logic                       empty,
    output logic [HBED_BLK_W-1:0]      block_col,
    output logic [HBED_BLK_W-1:0]      block_row,
    output logic                       is_edge
);

    localparam int HW = HBED_PIX_W + 3;   // signed coefficient width
    localparam int SW = HBED_PIX_W + 1;   // absolute coefficient width
    localparam int QW = 2 * SW;           // one square
    localparam int TW = SW + 2;           // sum of three
    localparam int LW = 2 * TW;           // three times the square sum
    localparam int RW = HBED_THR_W + 6;   // 36 times the threshold

    logic adv;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic signed [HW-1:0] ea, eb, ec, ed, h1, h2, h3, t1, t2, t3;
    logic [SW-1:0] s1_reg, s2_reg, s3_reg;
    logic [QW-1:0] sq1_reg, sq2_reg, sq3_reg;
    logic [TW-1:0] sum_reg;
    logic [LW-1:0] sqsum;
    logic [LW-1:0] tsq_reg, sum2_reg;
    logic [LW-1:0] lhs;
    logic [RW-1:0] rhs;

    logic [HBED_BLK_W-1:0] col1_reg, col2_reg, col3_reg, col4_reg;
    logic [HBED_BLK_W-1:0] row1_reg, row2_reg, row3_reg, row4_reg;
    logic                  edge_reg;

    // whole pipeline moves when the output register is free or taken
    assign adv  = !v4_reg || pop;
    assign q_rd = adv && !q_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= !q_empty;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // ac coefficients and their magnitudes
    always_comb
    begin
        ea = HW'(signed'({3'b000, q_head.a}));
        eb = HW'(signed'({3'b000, q_head.b}));
        ec = HW'(signed'({3'b000, q_head.c}));
        ed = HW'(signed'({3'b000, q_head.d}));
        h1 = ea - eb + ec - ed;
        h2 = ea + eb - ec - ed;
        h3 = ea - eb - ec + ed;
        t1 = h1[HW-1] ? -h1 : h1;
        t2 = h2[HW-1] ? -h2 : h2;
        t3 = h3[HW-1] ? -h3 : h3;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg   <= t1[SW-1:0];
            s2_reg   <= t2[SW-1:0];
            s3_reg   <= t3[SW-1:0];
            col1_reg <= q_head.block_col;
            row1_reg <= q_head.block_row;
        end
    end

    // squares and plain sum
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq1_reg  <= QW'(s1_reg) * QW'(s1_reg);
            sq2_reg  <= QW'(s2_reg) * QW'(s2_reg);
            sq3_reg  <= QW'(s3_reg) * QW'(s3_reg);
            sum_reg  <= TW'(s1_reg) + TW'(s2_reg) + TW'(s3_reg);
            col2_reg <= col1_reg;
            row2_reg <= row1_reg;
        end
    end

    // three times the square sum against the squared sum
    assign sqsum = LW'(sq1_reg) + LW'(sq2_reg) + LW'(sq3_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tsq_reg  <= (sqsum << 1) + sqsum;
            sum2_reg <= LW'(sum_reg) * LW'(sum_reg);
            col3_reg <= col2_reg;
            row3_reg <= row2_reg;
        end
    end

    // variance compare, never negative on the left side
    assign lhs = tsq_reg - sum2_reg;
    assign rhs = (RW'(variance_threshold) << 5) + (RW'(variance_threshold) << 2);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            edge_reg <= (lhs > LW'(rhs));
            col4_reg <= col3_reg;
            row4_reg <= row3_reg;
        end
    end

    assign empty     = !v4_reg;
    assign block_col = col4_reg;
    assign block_row = row4_reg;
    assign is_edge   = edge_reg;

endmodule

`default_nettype wire

[hw/rtl/hadamard_block_edge_detector_core.sv]
// ----------------------------------------------------------------------------
// hadamard_block_edge_detector_core
// 2x2 hadamard block edge detector on a row-major pixel stream
// ----------------------------------------------------------------------------
// Pixels are pushed one per transaction in row-major order, one per clock at
// full rate. Each lower-right pixel of a full 2x2 block yields one result on
// the output after its block passes the store read stage, the block queue and
// the four back pipeline registers, flagging an edge when the variance of
// the three hadamard ac magnitudes exceeds variance_threshold; other pixels
// yield no result. The rate is one pixel per cycle, set by the single read or
// write of the line store per pixel and by the back pipeline taking one block
// per cycle; a four-entry queue between the two lets either side stall. The
// line store needs no clearing pass after reset, as the upper row of a pair
// is always written before it is read. cfg_ready is always high; configuration
// should be written only while no pixel or result is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hadamard_block_edge_detector_core_macros.svh"

module hadamard_block_edge_detector_core
    import hbed_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    output logic                            full,
    input  wire logic [HBED_PIX_W-1:0]      pixel,
    input  wire logic                       frame_start,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [HBED_BLK_W-1:0]           block_col,
    output logic [HBED_BLK_W-1:0]           block_row,
    output logic                            is_edge,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [HBED_IDX_W-1:0]      cfg_index,
    input  wire logic [HBED_CFG_DATA_W-1:0] cfg_data
);

    logic [HBED_IMG_W_W-1:0] image_width_reg, image_width_next;
    logic [HBED_THR_W-1:0]   threshold_reg, threshold_next;

    logic                job_valid;
    hbed_job_t           job;
    hbed_job_t           q_head;
    logic                q_rd;
    logic                q_empty;
    logic [HBED_QCW-1:0] q_count;

    // configuration registers, writes to unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        image_width_next = image_width_reg;
        threshold_next   = threshold_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_IDX_IMAGE_WIDTH: image_width_next = cfg_data[HBED_IMG_W_W-1:0];
                CFG_IDX_THRESHOLD:   threshold_next   = cfg_data[HBED_THR_W-1:0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= HBED_IMG_W_RESET;
            threshold_reg   <= HBED_THR_RESET;
        end
        else
        begin
            image_width_reg <= image_width_next;
            threshold_reg   <= threshold_next;
        end
    end

    // front: position, line store and block assembly
    hbed_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .pixel       (pixel),
        .frame_start (frame_start),
        .image_width (image_width_reg),
        .q_count     (q_count),
        .job_valid   (job_valid),
        .job         (job)
    );

    // block queue
    hbed_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_valid),
        .wr_data (job),
        .rd_en   (q_rd),
        .rd_data (q_head),
        .count   (q_count),
        .empty   (q_empty)
    );

    // back: coefficient arithmetic and variance test
    hbed_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .q_empty            (q_empty),
        .q_head             (q_head),
        .q_rd               (q_rd),
        .variance_threshold (threshold_reg),
        .pop                (pop),
        .empty              (empty),
        .block_col          (block_col),
        .block_row          (block_row),
        .is_edge            (is_edge)
    );

    // queue bookkeeping checks
    `HBED_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, job_valid, q_count < HBED_QCW'(HBED_QDEPTH), "block queue written while full")
    `HBED_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, q_rd, !q_empty, "block queue read while empty")
    `HBED_ASSERT_IMPLIES(a_full_when_queue_full, clk, rst_n, q_count == HBED_QCW'(HBED_QDEPTH), full, "pixel input open with queue full")
    `HBED_ASSERT_NEXT(a_count_step, clk, rst_n, job_valid && !q_rd, q_count == $past(q_count) + HBED_QCW'(1), "queue count did not follow a write")

endmodule

`default_nettype wire
